FILE: hdl/frt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Shared constants, slot and event types and the helper that builds a fresh
// missing map for the cells, the output queue and the top level.
// ----------------------------------------------------------------------------
package frt_pkg;

    localparam logic [31:0] MAGIC_VALUE  = 32'h314C564D;
    localparam int          MAX_PACKETS  = 64;
    localparam int          KEEP_FRAMES  = 3;
    localparam int          HEADER_BYTES = 40;

    localparam int MAP_W    = 64;
    localparam int IDX_W    = 6;
    localparam int PKT_W    = 7;
    localparam int RCV_W    = 16;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 72;
    localparam int M_USER_W = 2;

    localparam logic [RCV_W-1:0] RCV_MAX = '1;

    typedef enum logic [1:0] {
        EVT_COMPLETE = 2'd0,
        EVT_RETIRE   = 2'd1,
        EVT_REJECT   = 2'd2
    } evt_kind_t;

    typedef struct packed {
        logic [31:0]      frame;
        logic [PKT_W-1:0] packets;
        logic [7:0]       copies;
        logic [MAP_W-1:0] missing;
        logic [PKT_W-1:0] lost;
        logic [RCV_W-1:0] received;
    } slot_t;

    typedef struct packed {
        logic             shift;
        logic             upd;
        logic [31:0]      frame;
        logic [IDX_W-1:0] index;
    } cell_cmd_t;

    typedef struct packed {
        logic             used;
        logic             match;
        logic             done;
        logic [RCV_W-1:0] rcv_next;
        slot_t            slot;
    } cell_view_t;

    typedef struct packed {
        evt_kind_t        kind;
        logic [31:0]      frame;
        logic [PKT_W-1:0] packets;
        logic [PKT_W-1:0] lost;
        logic [RCV_W-1:0] received;
        logic [7:0]       copies;
        logic             last;
    } evt_t;

    function automatic logic [MAP_W-1:0] first_bits(input logic [7:0] count);
        logic [MAP_W-1:0] m;
        for (int i = 0; i < MAP_W; i++)
        begin
            m[i] = (8'(i) < count);
        end
        return m;
    endfunction

endpackage

FILE: hdl/fragment_reassembly_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Tracks which packets of the pending video frames have arrived and reports
// completed, retired and rejected frames.
// ----------------------------------------------------------------------------
// Each item on the slave stream is one received packet header. The block
// checks it, matches it against a chain of pending frame cells, clears the
// packet's bit in that frame's missing map and counts the reception.
// Each item on the master stream is one event: a frame completed, the oldest
// frame retired once more than three are pending, or a packet rejected.
// An item gives zero, one or two events; tlast marks the last of them.
// The header is registered on acceptance and evaluated from that register;
// an item with two events fills both entries of the output queue.
// Evaluation waits for the output queue to be empty, so a stalled receiver
// holds the block after the next header has been taken. Reset empties all
// pending frame cells and the output queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // magic_word, frame_number, packet_count, pkt_index, copies_sent,
    // copy_index, payload_start, packet_length
    input  logic [frt_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // event_frame, frame_packets, lost_count, received_total, frame_copies,
    // zero padding
    output logic [frt_pkg::M_DATA_W-1:0]   m_tdata,
    // event_kind
    output logic [frt_pkg::M_USER_W-1:0]   m_tuser,
    output logic                           m_tlast
);
    import frt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } state_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [31:0] frame;
        logic [7:0]  count;
        logic [7:0]  index;
        logic [7:0]  copies;
        logic [7:0]  copy_idx;
        logic [15:0] start;
        logic [15:0] length;
    } hdr_t;

    state_t                 state_reg;
    state_t                 state_next;
    hdr_t                   hdr_reg;
    logic                   accept;
    logic                   fire;
    logic                   q_empty;
    cell_cmd_t              cmd;
    slot_t                  fresh;
    cell_view_t             view [KEEP_FRAMES];
    cell_view_t             sel;
    logic [KEEP_FRAMES-1:0] used_vec;
    logic [KEEP_FRAMES-1:0] match_vec;
    logic [KEEP_FRAMES-1:0] load_vec;
    logic [KEEP_FRAMES:0]   used_ext;
    logic                   hdr_ok;
    logic                   hit;
    logic                   ok;
    logic                   full;
    logic                   alloc;
    logic                   have_c;
    logic                   have_r;
    evt_t                   evt_c;
    evt_t                   evt_r;
    evt_t                   evt_rej;
    evt_t                   first;
    evt_t                   second;
    logic                   first_valid;
    logic                   second_valid;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_EVAL) && q_empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdr_reg.magic    <= s_tdata[31:0];
            hdr_reg.frame    <= s_tdata[63:32];
            hdr_reg.count    <= s_tdata[71:64];
            hdr_reg.index    <= s_tdata[79:72];
            hdr_reg.copies   <= s_tdata[87:80];
            hdr_reg.copy_idx <= s_tdata[95:88];
            hdr_reg.start    <= s_tdata[111:96];
            hdr_reg.length   <= s_tdata[127:112];
        end
    end

    always_comb
    begin
        hdr_ok = (hdr_reg.magic == MAGIC_VALUE)
              && (hdr_reg.start >= 16'(HEADER_BYTES))
              && (hdr_reg.start < hdr_reg.length)
              && (hdr_reg.count != 8'd0)
              && (hdr_reg.count <= 8'(MAX_PACKETS))
              && (hdr_reg.index < hdr_reg.count)
              && (hdr_reg.copies != 8'd0)
              && (hdr_reg.copy_idx < hdr_reg.copies);

        sel = '0;
        for (int i = 0; i < KEEP_FRAMES; i++)
        begin
            used_vec[i]  = view[i].used;
            match_vec[i] = view[i].match;
            if (view[i].match)
            begin
                sel = cell_view_t'(sel | view[i]);
            end
        end

        hit   = |match_vec;
        ok    = hdr_ok && !(hit && (({1'b0, sel.slot.packets} != hdr_reg.count)
                                 || (sel.slot.copies != hdr_reg.copies)));
        full  = used_vec[KEEP_FRAMES-1];
        alloc = fire && ok && !hit;

        fresh.frame    = hdr_reg.frame;
        fresh.packets  = hdr_reg.count[PKT_W-1:0];
        fresh.copies   = hdr_reg.copies;
        fresh.missing  = first_bits(hdr_reg.count)
                       & ~(MAP_W'(1) << hdr_reg.index[IDX_W-1:0]);
        fresh.lost     = hdr_reg.count[PKT_W-1:0] - 1'b1;
        fresh.received = RCV_W'(1);

        cmd.shift = alloc && full;
        cmd.upd   = fire && ok && hit;
        cmd.frame = hdr_reg.frame;
        cmd.index = hdr_reg.index[IDX_W-1:0];

        for (int i = 0; i < KEEP_FRAMES; i++)
        begin
            load_vec[i] = alloc && !full && !used_vec[i]
                       && ((i == 0) ? 1'b1 : used_vec[(i == 0) ? 0 : i - 1]);
        end

        have_c = ok && (hit ? sel.done : (hdr_reg.count == 8'd1));
        have_r = ok && !hit && full;

        evt_c.kind     = EVT_COMPLETE;
        evt_c.frame    = hdr_reg.frame;
        evt_c.packets  = hdr_reg.count[PKT_W-1:0];
        evt_c.lost     = '0;
        evt_c.received = hit ? sel.rcv_next : RCV_W'(1);
        evt_c.copies   = hdr_reg.copies;
        evt_c.last     = !have_r;

        evt_r.kind     = EVT_RETIRE;
        evt_r.frame    = view[0].slot.frame;
        evt_r.packets  = view[0].slot.packets;
        evt_r.lost     = view[0].slot.lost;
        evt_r.received = view[0].slot.received;
        evt_r.copies   = view[0].slot.copies;
        evt_r.last     = 1'b1;

        evt_rej.kind     = EVT_REJECT;
        evt_rej.frame    = hdr_reg.frame;
        evt_rej.packets  = '0;
        evt_rej.lost     = '0;
        evt_rej.received = '0;
        evt_rej.copies   = '0;
        evt_rej.last     = 1'b1;

        if (!ok)
        begin
            first        = evt_rej;
            first_valid  = 1'b1;
            second       = evt_r;
            second_valid = 1'b0;
        end
        else if (have_c)
        begin
            first        = evt_c;
            first_valid  = 1'b1;
            second       = evt_r;
            second_valid = have_r;
        end
        else
        begin
            first        = evt_r;
            first_valid  = have_r;
            second       = evt_r;
            second_valid = 1'b0;
        end
    end

    for (genvar g = 0; g < KEEP_FRAMES; g++)
    begin : g_cell
        if (g == KEEP_FRAMES - 1)
        begin : g_tail
            frt_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .load    (load_vec[g]),
                .fresh   (fresh),
                .up_used (1'b1),
                .up_slot (fresh),
                .view    (view[g])
            );
        end
        else
        begin : g_body
            frt_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .load    (load_vec[g]),
                .fresh   (fresh),
                .up_used (view[g+1].used),
                .up_slot (view[g+1].slot),
                .view    (view[g])
            );
        end
    end

    frt_out_queue u_out_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .first        (first),
        .first_valid  (first_valid),
        .second       (second),
        .second_valid (second_valid),
        .empty        (q_empty),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    assign used_ext = {1'b0, used_vec};

    // Pending frames stay packed from the oldest cell upwards.
    a_packed_chain : assert property (@(posedge clk) disable iff (!rst_n)
        ((used_ext + 1'b1) & used_ext) == '0)
        else $error("pending frame cells are not packed from the oldest cell");

    // A frame number is held by at most one pending cell.
    a_single_match : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one cell holds the same frame");

    // An evaluation with events leaves a result waiting on the master side.
    a_event_shown : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && first_valid) |=> m_tvalid)
        else $error("events of an evaluated item were not presented");

    // Retirement only happens when a new frame enters a full chain.
    a_retire_full : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |-> (full && !hit && hdr_ok))
        else $error("chain shifted without a full allocation");

endmodule

FILE: hdl/frt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending frame cell
// Holds one pending frame, matches it against the current packet, applies
// the packet to its missing map and takes its upper neighbour's frame when
// the chain moves down on retirement.
// ----------------------------------------------------------------------------
module frt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  frt_pkg::cell_cmd_t cmd,
    input  logic               load,
    input  frt_pkg::slot_t     fresh,
    input  logic               up_used,
    input  frt_pkg::slot_t     up_slot,
    output frt_pkg::cell_view_t view
);
    import frt_pkg::*;

    logic             used_reg;
    logic             used_next;
    slot_t            slot_reg;
    slot_t            slot_next;
    logic             match;
    logic             bit_set;
    logic [MAP_W-1:0] map_upd;
    logic [RCV_W-1:0] rcv_next;

    always_comb
    begin
        match    = used_reg && (slot_reg.frame == cmd.frame);
        bit_set  = slot_reg.missing[cmd.index];
        map_upd  = slot_reg.missing & ~(MAP_W'(1) << cmd.index);
        rcv_next = (slot_reg.received == RCV_MAX) ? slot_reg.received
                                                  : slot_reg.received + 1'b1;

        used_next = used_reg;
        slot_next = slot_reg;
        if (cmd.shift)
        begin
            used_next = up_used;
            slot_next = up_slot;
        end
        else if (load)
        begin
            used_next = 1'b1;
            slot_next = fresh;
        end
        else if (cmd.upd && match)
        begin
            slot_next.missing  = map_upd;
            slot_next.received = rcv_next;
            if (bit_set)
            begin
                slot_next.lost = slot_reg.lost - 1'b1;
            end
        end

        view.used     = used_reg;
        view.match    = match;
        view.done     = match && (slot_reg.missing != '0) && (map_upd == '0);
        view.rcv_next = rcv_next;
        view.slot     = slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

FILE: hdl/frt_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event output queue
// Two-entry queue that holds the events of one packet and presents them on
// the master stream, one item per handshake.
// ----------------------------------------------------------------------------
module frt_out_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  frt_pkg::evt_t                  first,
    input  logic                           first_valid,
    input  frt_pkg::evt_t                  second,
    input  logic                           second_valid,
    output logic                           empty,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // event_frame, frame_packets, lost_count, received_total, frame_copies,
    // zero padding
    output logic [frt_pkg::M_DATA_W-1:0]   m_tdata,
    // event_kind
    output logic [frt_pkg::M_USER_W-1:0]   m_tuser,
    output logic                           m_tlast
);
    import frt_pkg::*;

    evt_t       q0_reg;
    evt_t       q1_reg;
    logic [1:0] v_reg;
    logic       pop;

    assign pop      = v_reg[0] && m_tready;
    assign empty    = !v_reg[0];
    assign m_tvalid = v_reg[0];
    assign m_tdata  = {2'b00, q0_reg.copies, q0_reg.received, q0_reg.lost,
                       q0_reg.packets, q0_reg.frame};
    assign m_tuser  = q0_reg.kind;
    assign m_tlast  = q0_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 2'b00;
        end
        else if (load)
        begin
            v_reg <= {first_valid && second_valid, first_valid};
        end
        else if (pop)
        begin
            v_reg <= {1'b0, v_reg[1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q0_reg <= first;
            q1_reg <= second;
        end
        else if (pop)
        begin
            q0_reg <= q1_reg;
        end
    end

endmodule
